[hdl/epi_pkg.sv]
// Shared types, constants and the micro-program for the epipolar inlier test.
package epi_pkg;

  // Fixed field widths.
  localparam int COEF_W     = 32;
  localparam int THR_W      = 32;
  localparam int RES_CNT_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int DIG_W      = 16;
  localparam int NUM_COEF   = 9;
  localparam int STEP_W     = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COEF_0_1  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_2_3  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_4_5  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_6_7  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd5;

  localparam logic [COEF_W-1:0] COEF_LAST_RESET = 32'h1000_0000;
  localparam logic [THR_W-1:0]  THR_RESET       = 32'd256;

  // Operand, addend and destination selects of one product step.
  typedef enum logic [2:0] {A_COEF, A_RA, A_RB, A_RD, A_THR} a_src_t;
  typedef enum logic [2:0] {B_X1, B_Y1, B_X2, B_Y2, B_RA, B_RB, B_RD, B_RN} b_src_t;
  typedef enum logic [1:0] {ADD_ZERO, ADD_COEF, ADD_RC} add_src_t;
  typedef enum logic [3:0] {
    DST_NONE, DST_RA, DST_RB, DST_RC, DST_RD, DST_RD2, DST_RN, DST_CHK1, DST_CHK2
  } dst_t;

  typedef struct packed {
    a_src_t   a_src;
    logic [3:0] a_idx;
    b_src_t   b_src;
    add_src_t add_src;
    logic [3:0] add_idx;
    logic     init;
    dst_t     dst;
  } step_t;

  // Command bundle from the sequencer to the datapath.
  typedef struct packed {
    logic     load_in;
    logic     setup;
    logic     mul;
    logic     top;
    logic     store;
    logic     load_res;
    step_t    op;
  } cmd_t;

  localparam logic [STEP_W-1:0] LAST_STEP = 5'd18;

  // Micro-program: sums of products that build the lines, the residual,
  // its square, the line norms and the threshold products.
  function automatic step_t prog(input logic [STEP_W-1:0] s);
    step_t r;
    case (s)
      5'd0:  r = '{A_COEF, 4'd0, B_X1, ADD_COEF, 4'd2, 1'b1, DST_NONE};
      5'd1:  r = '{A_COEF, 4'd1, B_Y1, ADD_ZERO, 4'd0, 1'b0, DST_RA};
      5'd2:  r = '{A_COEF, 4'd3, B_X1, ADD_COEF, 4'd5, 1'b1, DST_NONE};
      5'd3:  r = '{A_COEF, 4'd4, B_Y1, ADD_ZERO, 4'd0, 1'b0, DST_RB};
      5'd4:  r = '{A_COEF, 4'd6, B_X1, ADD_COEF, 4'd8, 1'b1, DST_NONE};
      5'd5:  r = '{A_COEF, 4'd7, B_Y1, ADD_ZERO, 4'd0, 1'b0, DST_RC};
      5'd6:  r = '{A_RA,   4'd0, B_X2, ADD_RC,   4'd0, 1'b1, DST_NONE};
      5'd7:  r = '{A_RB,   4'd0, B_Y2, ADD_ZERO, 4'd0, 1'b0, DST_RD};
      5'd8:  r = '{A_RD,   4'd0, B_RD, ADD_ZERO, 4'd0, 1'b1, DST_RD2};
      5'd9:  r = '{A_RA,   4'd0, B_RA, ADD_ZERO, 4'd0, 1'b1, DST_NONE};
      5'd10: r = '{A_RB,   4'd0, B_RB, ADD_ZERO, 4'd0, 1'b0, DST_RN};
      5'd11: r = '{A_THR,  4'd0, B_RN, ADD_ZERO, 4'd0, 1'b1, DST_CHK1};
      5'd12: r = '{A_COEF, 4'd0, B_X2, ADD_COEF, 4'd6, 1'b1, DST_NONE};
      5'd13: r = '{A_COEF, 4'd3, B_Y2, ADD_ZERO, 4'd0, 1'b0, DST_RA};
      5'd14: r = '{A_COEF, 4'd1, B_X2, ADD_COEF, 4'd7, 1'b1, DST_NONE};
      5'd15: r = '{A_COEF, 4'd4, B_Y2, ADD_ZERO, 4'd0, 1'b0, DST_RB};
      5'd16: r = '{A_RA,   4'd0, B_RA, ADD_ZERO, 4'd0, 1'b1, DST_NONE};
      5'd17: r = '{A_RB,   4'd0, B_RB, ADD_ZERO, 4'd0, 1'b0, DST_RN};
      5'd18: r = '{A_THR,  4'd0, B_RN, ADD_ZERO, 4'd0, 1'b1, DST_CHK2};
      default: r = '{A_THR, 4'd0, B_RN, ADD_ZERO, 4'd0, 1'b0, DST_NONE};
    endcase
    return r;
  endfunction

endpackage

[hdl/epi_if.sv]
// Channel interfaces: point correspondences, test results and register writes.
interface epi_pt_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_first;
  logic signed [COORD_BITS-1:0] y_first;
  logic signed [COORD_BITS-1:0] x_second;
  logic signed [COORD_BITS-1:0] y_second;
  logic                         last_point;
  modport source (output valid, x_first, y_first, x_second, y_second, last_point,
                  input ready);
  modport sink (input valid, x_first, y_first, x_second, y_second, last_point,
                output ready);
endinterface

interface epi_res_if;
  logic        valid;
  logic        ready;
  logic        is_inlier;
  logic [15:0] inliers_so_far;
  logic        set_done;
  modport source (output valid, is_inlier, inliers_so_far, set_done, input ready);
  modport sink (input valid, is_inlier, inliers_so_far, set_done, output ready);
endinterface

interface epi_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/epipolar_inlier_test_unit.sv]
// Top level of the symmetric epipolar distance inlier test.
//
// Channels: pts takes one point correspondence per transfer (Q12.4
// coordinates and a last-of-set mark); res returns one result per point:
// the inlier flag, the running inlier count of the set and the set end echo.
// cfg writes the six registers (four coefficient pairs, entry 8, squared
// threshold); it is always ready, and the user must write it only while the
// unit is idle: the unit itself does not enforce this. Each point runs a
// fixed 19-step program on one shared 16-bit digit multiplier with a wide
// accumulator; each step passes through setup, its digit multiplies, a drain
// and a store. The next point is taken only once the result of the last one
// is registered, so points are worked on one at a time.
// A result waits in the output register while res is stalled; the next point
// is still taken and worked on, and holds at its end until the register frees.
// Reset clears the sequencer, the inlier tally and the output valid, and
// returns the registers to an identity last entry and a threshold of one.
// The tally saturates and clears after the result marked as set end.
module epipolar_inlier_test_unit #(
  parameter int COUNT_BITS = 16,
  parameter int COORD_BITS = 16
) (
  input logic      clk,
  input logic      rst,
  epi_pt_if.sink   pts,
  epi_res_if.source res,
  epi_cfg_if.sink  cfg
);

  localparam int LW     = COORD_BITS + 34;
  localparam int NDIG_N = (2 * LW + epi_pkg::DIG_W - 1) / epi_pkg::DIG_W;
  localparam int DIGW   = $clog2(NDIG_N);

  epi_pkg::cmd_t   cmd;
  logic [DIGW-1:0] k;
  logic            cfg_we;

  // Register writes are taken in any cycle.
  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;

  epi_ctrl #(
    .COORD_BITS(COORD_BITS),
    .DIGW      (DIGW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pts.valid),
    .in_ready (pts.ready),
    .out_valid(res.valid),
    .out_ready(res.ready),
    .cmd      (cmd),
    .k        (k)
  );

  epi_datapath #(
    .COORD_BITS(COORD_BITS),
    .COUNT_BITS(COUNT_BITS),
    .DIGW      (DIGW)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .k             (k),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg.index),
    .cfg_data      (cfg.data),
    .x_first       (pts.x_first),
    .y_first       (pts.y_first),
    .x_second      (pts.x_second),
    .y_second      (pts.y_second),
    .last_point    (pts.last_point),
    .is_inlier     (res.is_inlier),
    .inliers_so_far(res.inliers_so_far),
    .set_done      (res.set_done)
  );

endmodule

[hdl/epi_datapath.sv]
// Datapath: registers, digit multiplier, wide accumulator and inlier tally.
module epi_datapath #(
  parameter int COORD_BITS = 16,
  parameter int COUNT_BITS = 16,
  parameter int DIGW       = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  epi_pkg::cmd_t                       cmd,
  input  logic [DIGW-1:0]                     k,
  input  logic                                cfg_we,
  input  logic [epi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [epi_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [COORD_BITS-1:0]        x_first,
  input  logic signed [COORD_BITS-1:0]        y_first,
  input  logic signed [COORD_BITS-1:0]        x_second,
  input  logic signed [COORD_BITS-1:0]        y_second,
  input  logic                                last_point,
  output logic                                is_inlier,
  output logic [epi_pkg::RES_CNT_W-1:0]       inliers_so_far,
  output logic                                set_done
);

  localparam int LW    = COORD_BITS + 34;
  localparam int DW    = LW + COORD_BITS + 2;
  localparam int NW    = 2 * LW;
  localparam int AW    = DW;
  localparam int WB    = NW;
  localparam int PW    = AW + epi_pkg::DIG_W + 1;
  localparam int ACC_W = 2 * DW;
  localparam int EXTW  = (COUNT_BITS > epi_pkg::RES_CNT_W) ? COUNT_BITS : epi_pkg::RES_CNT_W;

  logic signed [epi_pkg::COEF_W-1:0] coef [epi_pkg::NUM_COEF];
  logic [epi_pkg::THR_W-1:0]         thr;

  logic signed [COORD_BITS-1:0] x1, y1, x2, y2;
  logic                         last_reg;
  logic signed [LW-1:0]         ra, rb, rc;
  logic signed [DW-1:0]         rd;
  logic signed [ACC_W-1:0]      rd2;
  logic signed [NW-1:0]         rn;
  logic                         ok;

  logic signed [AW-1:0]    a_opd;
  logic signed [WB-1:0]    b_sr;
  logic signed [PW-1:0]    prod;
  logic [DIGW-1:0]         prod_sh;
  logic                    prod_vld;
  logic signed [ACC_W-1:0] acc;
  logic [COUNT_BITS-1:0]   tally;

  logic signed [AW-1:0]             a_next;
  logic signed [WB-1:0]             b_next;
  logic signed [ACC_W-1:0]          add_val;
  logic signed [epi_pkg::DIG_W:0]   digit;
  logic signed [ACC_W-1:0]          prod_ext;
  logic                             dist_ok;
  logic [COUNT_BITS-1:0]            tally_upd;
  logic [EXTW-1:0]                  tally_ext;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < epi_pkg::NUM_COEF - 1; i++) begin
        coef[i] <= '0;
      end
      coef[8] <= epi_pkg::COEF_LAST_RESET;
      thr     <= epi_pkg::THR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        epi_pkg::REG_COEF_0_1: begin
          coef[0] <= cfg_data[31:0];
          coef[1] <= cfg_data[63:32];
        end
        epi_pkg::REG_COEF_2_3: begin
          coef[2] <= cfg_data[31:0];
          coef[3] <= cfg_data[63:32];
        end
        epi_pkg::REG_COEF_4_5: begin
          coef[4] <= cfg_data[31:0];
          coef[5] <= cfg_data[63:32];
        end
        epi_pkg::REG_COEF_6_7: begin
          coef[6] <= cfg_data[31:0];
          coef[7] <= cfg_data[63:32];
        end
        epi_pkg::REG_COEF_LAST: coef[8] <= cfg_data[31:0];
        epi_pkg::REG_THRESHOLD: thr <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Operand and addend selection for the next product step.
  always_comb begin
    case (cmd.op.a_src)
      epi_pkg::A_COEF: a_next = AW'(coef[cmd.op.a_idx]);
      epi_pkg::A_RA:   a_next = AW'(ra);
      epi_pkg::A_RB:   a_next = AW'(rb);
      epi_pkg::A_RD:   a_next = AW'(rd);
      default:         a_next = AW'({1'b0, thr});
    endcase
    case (cmd.op.b_src)
      epi_pkg::B_X1: b_next = WB'(x1);
      epi_pkg::B_Y1: b_next = WB'(y1);
      epi_pkg::B_X2: b_next = WB'(x2);
      epi_pkg::B_Y2: b_next = WB'(y2);
      epi_pkg::B_RA: b_next = WB'(ra);
      epi_pkg::B_RB: b_next = WB'(rb);
      epi_pkg::B_RD: b_next = WB'(rd);
      default:       b_next = WB'(rn);
    endcase
    case (cmd.op.add_src)
      epi_pkg::ADD_COEF: add_val = ACC_W'(coef[cmd.op.add_idx]) <<< 4;
      epi_pkg::ADD_RC:   add_val = ACC_W'(rc) <<< 4;
      default:           add_val = '0;
    endcase
  end

  // Low digits are unsigned, the top digit carries the sign.
  always_comb begin
    if (cmd.top) begin
      digit = {b_sr[epi_pkg::DIG_W-1], b_sr[epi_pkg::DIG_W-1:0]};
    end else begin
      digit = {1'b0, b_sr[epi_pkg::DIG_W-1:0]};
    end
    prod_ext = ACC_W'(prod) <<< {prod_sh, 4'b0000};
    dist_ok  = (rn != '0) && (rd2 <= acc);
  end

  // Digit multiplier and accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.mul;
    end
    if (cmd.setup) begin
      a_opd <= a_next;
      b_sr  <= b_next;
      if (cmd.op.init) begin
        acc <= add_val;
      end
    end else if (prod_vld) begin
      acc <= acc + prod_ext;
    end
    if (cmd.mul) begin
      prod    <= a_opd * digit;
      prod_sh <= k;
      b_sr    <= b_sr >>> epi_pkg::DIG_W;
    end
  end

  // Input capture and result registers of each step.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x1       <= x_first;
      y1       <= y_first;
      x2       <= x_second;
      y2       <= y_second;
      last_reg <= last_point;
    end
    if (cmd.store) begin
      case (cmd.op.dst)
        epi_pkg::DST_RA:   ra  <= acc[LW-1:0];
        epi_pkg::DST_RB:   rb  <= acc[LW-1:0];
        epi_pkg::DST_RC:   rc  <= acc[LW-1:0];
        epi_pkg::DST_RD:   rd  <= acc[DW-1:0];
        epi_pkg::DST_RD2:  rd2 <= acc;
        epi_pkg::DST_RN:   rn  <= acc[NW-1:0];
        epi_pkg::DST_CHK1: ok  <= dist_ok;
        epi_pkg::DST_CHK2: ok  <= ok & dist_ok;
        default: ;
      endcase
    end
  end

  // Saturating tally and the result register.
  always_comb begin
    tally_upd = tally + COUNT_BITS'(ok && (tally != '1));
    tally_ext = EXTW'(tally_upd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tally <= '0;
    end else if (cmd.load_res) begin
      tally <= last_reg ? '0 : tally_upd;
    end
    if (cmd.load_res) begin
      is_inlier      <= ok;
      inliers_so_far <= tally_ext[epi_pkg::RES_CNT_W-1:0];
      set_done       <= last_reg;
    end
  end

endmodule

[hdl/epi_ctrl.sv]
// Sequencer: steps through the micro-program and drives the handshakes.
module epi_ctrl #(
  parameter int COORD_BITS = 16,
  parameter int DIGW       = 3
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output epi_pkg::cmd_t   cmd,
  output logic [DIGW-1:0] k
);

  localparam int LW     = COORD_BITS + 34;
  localparam int DW     = LW + COORD_BITS + 2;
  localparam int NW     = 2 * LW;
  localparam int NDIG_C = (COORD_BITS + epi_pkg::DIG_W - 1) / epi_pkg::DIG_W;
  localparam int NDIG_L = (LW + epi_pkg::DIG_W - 1) / epi_pkg::DIG_W;
  localparam int NDIG_D = (DW + epi_pkg::DIG_W - 1) / epi_pkg::DIG_W;
  localparam int NDIG_N = (NW + epi_pkg::DIG_W - 1) / epi_pkg::DIG_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SETUP  = 6'b000010,
    S_MUL    = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_STORE  = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t                     state, state_next;
  logic [epi_pkg::STEP_W-1:0] step;
  logic [DIGW-1:0]            dig;
  logic [DIGW-1:0]            ndig_m1;
  epi_pkg::step_t             row;
  logic                       res_free;

  // Decode the current step and its digit count.
  always_comb begin
    row = epi_pkg::prog(step);
    case (row.b_src)
      epi_pkg::B_RA, epi_pkg::B_RB: ndig_m1 = DIGW'(NDIG_L - 1);
      epi_pkg::B_RD:                ndig_m1 = DIGW'(NDIG_D - 1);
      epi_pkg::B_RN:                ndig_m1 = DIGW'(NDIG_N - 1);
      default:                      ndig_m1 = DIGW'(NDIG_C - 1);
    endcase
    res_free = !out_valid || out_ready;
    in_ready = (state == S_IDLE);
    k        = dig;
  end

  // Commands and next state.
  always_comb begin
    cmd          = '0;
    cmd.op       = row;
    cmd.top      = (dig == ndig_m1);
    state_next   = state;
    case (state)
      S_IDLE: begin
        cmd.load_in = in_valid;
        if (in_valid) state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (dig == ndig_m1) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_STORE;
      S_STORE: begin
        cmd.store  = 1'b1;
        state_next = (step == epi_pkg::LAST_STEP) ? S_RESULT : S_SETUP;
      end
      S_RESULT: begin
        cmd.load_res = res_free;
        if (res_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      dig       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.load_res || (out_valid && !out_ready);
      if (state == S_IDLE) begin
        step <= '0;
      end else if (state == S_STORE) begin
        step <= step + 1'b1;
      end
      if (state == S_SETUP) begin
        dig <= '0;
      end else if (state == S_MUL) begin
        dig <= dig + 1'b1;
      end
    end
  end

endmodule

[bench/tb_score.sv]
// Expected-result store and checker for the epipolar inlier test bench.
`timescale 1ns / 1ps
class inlier_score;
  typedef struct packed {
    logic        is_inlier;
    logic [15:0] count;
    logic        done;
  } verdict_t;

  verdict_t pending[$];
  int       errors;

  function new();
    errors = 0;
  endfunction

  // Queue the verdict predicted for an accepted point.
  function void note_point(logic inl, logic [15:0] cnt, logic dn);
    verdict_t v;
    v.is_inlier = inl;
    v.count     = cnt;
    v.done      = dn;
    pending = {pending, v};
  endfunction

  // Compare one transferred result against the oldest expectation.
  function void check_result(logic inl, logic [15:0] cnt, logic dn);
    verdict_t v;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result inlier=%0d count=%0d done=%0d", $time, inl, cnt, dn);
      errors++;
      return;
    end
    v = pending.pop_front();
    if (v.is_inlier !== inl) begin
      $display("%0t: is_inlier expected %0d got %0d", $time, v.is_inlier, inl);
      errors++;
    end
    if (v.count !== cnt) begin
      $display("%0t: inliers_so_far expected %0d got %0d", $time, v.count, cnt);
      errors++;
    end
    if (v.done !== dn) begin
      $display("%0t: set_done expected %0d got %0d", $time, v.done, dn);
      errors++;
    end
  endfunction
endclass

[bench/tb.sv]
// Top-level bench: drives points and register writes, predicts and checks results.
`timescale 1ns / 1ps
module tb;

  localparam int CBITS = 16;
  localparam int LAT   = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;

  epi_pt_if #(.COORD_BITS(16)) pts();
  epi_res_if res();
  epi_cfg_if cfg();

  epipolar_inlier_test_unit #(.COUNT_BITS(CBITS), .COORD_BITS(16)) uut (
    .clk(clk), .rst(rst), .pts(pts), .res(res), .cfg(cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  inlier_score board = new();

  // Predictor copy of the register file and the running tally.
  logic signed [31:0] fmat[9];
  logic [31:0]        thr;
  logic [CBITS-1:0]   tally;
  bit                 hold_long;
  bit                 sending;

  // Apply a register write to the predictor copy.
  function automatic void shadow_write(logic [2:0] idx, logic [63:0] val);
    case (idx)
      epi_pkg::REG_COEF_0_1: begin fmat[0] = val[31:0]; fmat[1] = val[63:32]; end
      epi_pkg::REG_COEF_2_3: begin fmat[2] = val[31:0]; fmat[3] = val[63:32]; end
      epi_pkg::REG_COEF_4_5: begin fmat[4] = val[31:0]; fmat[5] = val[63:32]; end
      epi_pkg::REG_COEF_6_7: begin fmat[6] = val[31:0]; fmat[7] = val[63:32]; end
      epi_pkg::REG_COEF_LAST: fmat[8] = val[31:0];
      epi_pkg::REG_THRESHOLD: thr = val[31:0];
      default: ;
    endcase
  endfunction

  // Cross-multiplied distance test for one line against the shared residual.
  function automatic bit line_ok(logic signed [255:0] d2, logic signed [255:0] la,
                                 logic signed [255:0] lb);
    logic signed [255:0] nrm;
    logic signed [255:0] lim;
    nrm = la * la + lb * lb;
    lim = $signed({224'd0, thr}) * nrm;
    if (nrm == 0) return 1'b0;
    return $unsigned(d2) <= $unsigned(lim);
  endfunction

  // Predict the verdict of one correspondence and update the tally.
  function automatic void predict_point(logic signed [15:0] x1, logic signed [15:0] y1,
                                        logic signed [15:0] x2, logic signed [15:0] y2,
                                        logic lst);
    logic signed [255:0] f[9];
    logic signed [255:0] px, py, qx, qy, la, lb, lc, d, d2;
    bit ok;
    for (int i = 0; i < 9; i++) f[i] = fmat[i];
    px = x1; py = y1; qx = x2; qy = y2;
    la = f[0] * px + f[1] * py + f[2] * 16;
    lb = f[3] * px + f[4] * py + f[5] * 16;
    lc = f[6] * px + f[7] * py + f[8] * 16;
    d  = qx * la + qy * lb + 16 * lc;
    d2 = d * d;
    ok = line_ok(d2, la, lb);
    la = f[0] * qx + f[3] * qy + f[6] * 16;
    lb = f[1] * qx + f[4] * qy + f[7] * 16;
    ok = ok && line_ok(d2, la, lb);
    if (ok && tally != {CBITS{1'b1}}) tally = tally + 1'b1;
    board.note_point(ok, tally[15:0], lst);
    if (lst) tally = '0;
  endfunction

  // One register write; the channel is sampled at the edge, then left idle.
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    shadow_write(idx, val);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one point, with a random gap first unless told otherwise.
  task automatic send_point(logic [15:0] x1, logic [15:0] y1, logic [15:0] x2,
                            logic [15:0] y2, logic lst, bit nogap);
    int gap;
    gap = nogap ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      pts.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pts.valid      <= 1'b1;
    pts.x_first    <= x1;
    pts.y_first    <= y1;
    pts.x_second   <= x2;
    pts.y_second   <= y2;
    pts.last_point <= lst;
    do @(posedge clk); while (!pts.ready);
    predict_point(x1, y1, x2, y2, lst);
  endtask

  task automatic idle_pts();
    pts.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every predicted result is back, then let the unit settle.
  task automatic drain();
    int guard;
    guard = 0;
    while (board.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LAT) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rnd_coef();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  // A random matrix, often one of the thin shapes that make small distances.
  task automatic program_matrix(int style);
    logic [31:0] c[9];
    for (int i = 0; i < 9; i++) c[i] = rnd_coef();
    if (style == 1) begin
      for (int i = 0; i < 9; i++) c[i] = 32'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
      c[8] = 32'h1000_0000;
    end
    write_reg(epi_pkg::REG_COEF_0_1, {c[1], c[0]});
    write_reg(epi_pkg::REG_COEF_2_3, {c[3], c[2]});
    write_reg(epi_pkg::REG_COEF_4_5, {c[5], c[4]});
    write_reg(epi_pkg::REG_COEF_6_7, {c[7], c[6]});
    write_reg(epi_pkg::REG_COEF_LAST, {32'($urandom), c[8]});
    write_reg(epi_pkg::REG_THRESHOLD, {32'($urandom), 32'($urandom)});
  endtask

  // Receiver: random stalls, plus one long hold while points keep coming.
  initial begin
    int w;
    res.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_long) begin
        res.ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_long = 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (w > 0) begin
        res.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
      board.check_result(res.is_inlier, res.inliers_so_far, res.set_done);
    end
  end

  initial begin
    #100ms;
    $display("tb: done, errors");
    $finish;
  end

  // Stimulus and final verdict.
  initial begin
    int n;
    logic [15:0] xs, ys, xt, yt;
    pts.valid <= 1'b0;
    pts.x_first <= '0; pts.y_first <= '0; pts.x_second <= '0; pts.y_second <= '0;
    pts.last_point <= 1'b0;
    cfg.valid <= 1'b0; cfg.index <= '0; cfg.data <= '0;
    hold_long = 1'b0;
    for (int i = 0; i < 8; i++) fmat[i] = '0;
    fmat[8] = epi_pkg::COEF_LAST_RESET;
    thr = epi_pkg::THR_RESET;
    tally = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset matrix: every line has zero norm, so all points are outliers.
    send_point(16'h8000, 16'h7fff, 16'h0000, 16'hffff, 1'b0, 0);
    send_point(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1'b1, 0);
    idle_pts();
    drain();

    // Coefficients 5 and 6 only: the residual vanishes where y2 equals x1.
    write_reg(epi_pkg::REG_COEF_0_1, 64'd0);
    write_reg(epi_pkg::REG_COEF_2_3, 64'd0);
    write_reg(epi_pkg::REG_COEF_4_5, {32'hf000_0000, 32'd0});
    write_reg(epi_pkg::REG_COEF_6_7, {32'd0, 32'h1000_0000});
    write_reg(epi_pkg::REG_COEF_LAST, 64'd0);
    write_reg(epi_pkg::REG_THRESHOLD, 64'd0);
    send_point(16'h0010, 16'h0020, 16'h0030, 16'h0020, 1'b0, 0);
    send_point(16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0, 0);
    send_point(16'h0010, 16'h0020, 16'h0030, 16'h0021, 1'b0, 0);
    send_point(16'hffff, 16'h8000, 16'h8000, 16'h8000, 1'b1, 0);
    idle_pts();
    drain();
    write_reg(epi_pkg::REG_THRESHOLD, 64'hffff_ffff_ffff_ffff);
    write_reg(epi_pkg::REG_THRESHOLD, 64'h0000_0000_ffff_ffff);
    send_point(16'h0010, 16'h0020, 16'h0030, 16'h7000, 1'b0, 0);
    send_point(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1'b1, 0);
    idle_pts();
    drain();

    // Extreme coefficients everywhere.
    write_reg(epi_pkg::REG_COEF_0_1, 64'h7fff_ffff_8000_0000);
    write_reg(epi_pkg::REG_COEF_2_3, 64'h8000_0000_7fff_ffff);
    write_reg(epi_pkg::REG_COEF_4_5, 64'h7fff_ffff_7fff_ffff);
    write_reg(epi_pkg::REG_COEF_6_7, 64'h8000_0000_8000_0000);
    write_reg(epi_pkg::REG_COEF_LAST, 64'h8000_0000);
    write_reg(3'd6, 64'h1234);
    write_reg(3'd7, 64'h5678);
    send_point(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0, 0);
    send_point(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 0);
    idle_pts();
    drain();

    // Random phases; the first one also holds the receiver off for a while.
    n = 0;
    for (int ph = 0; ph < 10; ph++) begin
      program_matrix($urandom_range(0, 1));
      if (ph == 0) hold_long = 1'b1;
      for (int k = 0; k < 80; k++) begin
        xs = rnd_coord(); ys = rnd_coord(); xt = rnd_coord(); yt = rnd_coord();
        if ($urandom_range(0, 2) == 0) begin
          xt = xs; yt = ys;
        end
        send_point(xs, ys, xt, yt, ($urandom_range(0, 15) == 0) || k == 79, ph == 0);
        n++;
      end
      idle_pts();
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      if (board.pending.size() != 0)
        $display("%0t: %0d results never arrived", $time, board.pending.size());
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
